### hdl/vmrp_pkg.sv
// Register offsets, op codes and fixed sizes shared by the video memory register port.
// Stand-alone package with no dependencies.
package vmrp_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register offsets above the port base.
    localparam logic [5:0] OFS_OAM_ADDR_LO  = 6'h02;
    localparam logic [5:0] OFS_OAM_ADDR_HI  = 6'h03;
    localparam logic [5:0] OFS_OAM_DATA     = 6'h04;
    localparam logic [5:0] OFS_SCROLL_A     = 6'h0D;
    localparam logic [5:0] OFS_SCROLL_B     = 6'h0E;
    localparam logic [5:0] OFS_VRAM_MODE    = 6'h15;
    localparam logic [5:0] OFS_VRAM_ADDR_LO = 6'h16;
    localparam logic [5:0] OFS_VRAM_ADDR_HI = 6'h17;
    localparam logic [5:0] OFS_VRAM_DATA_LO = 6'h18;
    localparam logic [5:0] OFS_VRAM_DATA_HI = 6'h19;
    localparam logic [5:0] OFS_MATRIX_A     = 6'h1B;
    localparam logic [5:0] OFS_MATRIX_B     = 6'h1C;
    localparam logic [5:0] OFS_MATRIX_C     = 6'h1D;
    localparam logic [5:0] OFS_MATRIX_D     = 6'h1E;
    localparam logic [5:0] OFS_CG_ADDR      = 6'h21;
    localparam logic [5:0] OFS_CG_DATA      = 6'h22;
    localparam logic [5:0] OFS_MPY_LO       = 6'h34;
    localparam logic [5:0] OFS_MPY_MID      = 6'h35;
    localparam logic [5:0] OFS_MPY_HI       = 6'h36;
    localparam logic [5:0] OFS_OAM_READ     = 6'h38;
    localparam logic [5:0] OFS_VRAM_READ_LO = 6'h39;
    localparam logic [5:0] OFS_VRAM_READ_HI = 6'h3A;
    localparam logic [5:0] OFS_CG_READ      = 6'h3B;
    localparam logic [5:0] OFS_VERSION_A    = 6'h3E;
    localparam logic [5:0] OFS_VERSION_B    = 6'h3F;

    // Object table: 544 bytes held as two byte banks of 272 rows.
    localparam logic [10:0] OBJ_DEPTH     = 11'd544;
    localparam logic [9:0]  OBJ_HIGH_BASE = 10'd512;
    localparam int          OBJ_ROWS      = 272;
    localparam int          OBJ_ROW_W     = 9;

    localparam logic [7:0]  VERSION_BYTE   = 8'h01;
    localparam logic [15:0] MATRIX_A_RESET = 16'h0100;

endpackage

### hdl/video_memory_register_port_top.sv
// An accepted input beat passes through the read state (memory read), then the exec state
// (modify and write back), before its result is registered in the output register. A new
// beat is taken only in the idle state; a stalled result holds off the next beat.
// Reset: a clearing pass over every video address zeroes the video, object and palette
// memories; the input is stalled until it ends. Control registers reset at once.
// Depends on vmrp_pkg.
module video_memory_register_port_top
    import vmrp_pkg::*;
#(
    parameter int VIDEO_DEPTH   = 32768,
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [5:0] reg_offset,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data
);

    localparam int VA_W = $clog2(VIDEO_DEPTH);
    localparam int PI_W = $clog2(PALETTE_DEPTH);

    // Reciprocals rounded up; exact quotients for every address the counters can hold.
    localparam longint unsigned VID_RECIP_L = ((64'd1 << 32) + VIDEO_DEPTH - 1) / VIDEO_DEPTH;
    localparam longint unsigned PAL_RECIP_L = (65536 + PALETTE_DEPTH - 1) / PALETTE_DEPTH;
    localparam logic [22:0] VID_RECIP = 23'(VID_RECIP_L);
    localparam logic [12:0] PAL_RECIP = 13'(PAL_RECIP_L);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    // Control state.
    state_t           state_reg, state_next;
    logic [VA_W-1:0]  clr_reg, clr_next;
    logic [15:0]      vaddr_reg, vaddr_next;
    logic [7:0]       step_reg, step_next;
    logic [15:0]      prefetch_reg, prefetch_next;
    logic [9:0]       oaddr_reg, oaddr_next;
    logic             ophase_reg, ophase_next;
    logic [7:0]       paddr_reg, paddr_next;
    logic             pphase_reg, pphase_next;
    logic [15:0]      mat_a_reg, mat_a_next;
    logic [15:0]      mat_b_reg, mat_b_next;
    logic [7:0]       prev_reg, prev_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic             op_reg;
    logic [5:0]       roff_reg;
    logic [7:0]       wdata_reg;
    logic [7:0]       olow_reg, olow_next;
    logic [7:0]       plow_reg, plow_next;
    logic [6:0]       vq_reg;
    logic [4:0]       pq_reg;
    logic [VA_W-1:0]  vidx_reg;
    logic [PI_W-1:0]  pidx_reg;
    logic [9:0]       oidx_reg;
    logic [7:0]       read_data_reg, read_data_next;

    // Memory ports.
    logic [15:0]          vmem [VIDEO_DEPTH];
    logic                 vmem_we;
    logic [VA_W-1:0]      vmem_waddr;
    logic [15:0]          vmem_wdata;
    logic [15:0]          vmem_rdata;
    logic [7:0]           obj_even [OBJ_ROWS];
    logic [7:0]           obj_odd [OBJ_ROWS];
    logic                 even_we, odd_we;
    logic [OBJ_ROW_W-1:0] even_waddr, odd_waddr;
    logic [7:0]           even_wdata, odd_wdata;
    logic [7:0]           even_rdata, odd_rdata;
    logic [14:0]          pmem [PALETTE_DEPTH];
    logic                 pmem_we;
    logic [PI_W-1:0]      pmem_waddr;
    logic [14:0]          pmem_wdata;
    logic [14:0]          pmem_rdata;
    logic                 mem_re;

    // Index arithmetic.
    logic [38:0]      vprod;
    logic [23:0]      vqd;
    logic [23:0]      vrem;
    logic [VA_W-1:0]  vidx;
    logic [20:0]      pprod;
    logic [15:0]      pqd;
    logic [15:0]      prem;
    logic [PI_W-1:0]  pidx;
    logic [9:0]       oidx;
    logic [10:0]      oinc;
    logic [10:0]      oinc_wrap;
    logic [9:0]       ohi;
    logic [15:0]      vstep;
    logic [15:0]      vinc;
    logic signed [23:0] product;
    logic             in_accept;
    logic             exec_go;
    logic             clear_done;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign mem_re    = (state_reg == ST_READ);
    assign clear_done = (clr_reg == VA_W'(VIDEO_DEPTH - 1));

    // Quotients are registered every cycle; addresses change only in the exec state, so they are stable before a read.
    assign vprod = {23'd0, vaddr_reg} * {16'd0, VID_RECIP};
    assign pprod = {13'd0, paddr_reg} * {8'd0, PAL_RECIP};
    assign vqd   = {17'd0, vq_reg} * 24'(VIDEO_DEPTH);
    assign vrem  = {8'd0, vaddr_reg} - vqd;
    assign vidx  = vrem[VA_W-1:0];
    assign pqd   = {11'd0, pq_reg} * 16'(PALETTE_DEPTH);
    assign prem  = {8'd0, paddr_reg} - pqd;
    assign pidx  = prem[PI_W-1:0];

    // Object read index and post-increment, both modulo the table size.
    assign oidx      = ({1'b0, oaddr_reg} >= OBJ_DEPTH) ? 10'({1'b0, oaddr_reg} - OBJ_DEPTH)
                                                        : oaddr_reg;
    assign oinc      = {1'b0, oaddr_reg} + 11'd1;
    assign oinc_wrap = (oinc >= OBJ_DEPTH) ? (oinc - OBJ_DEPTH) : oinc;
    assign ohi       = oaddr_reg + 10'd1;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    vinc = 16'd1;
            2'd1:    vinc = 16'd32;
            default: vinc = 16'd128;
        endcase
    end
    assign vstep = vaddr_reg + vinc;

    assign product = $signed({{8{mat_a_reg[15]}}, mat_a_reg})
                   * $signed({{16{mat_b_reg[15]}}, mat_b_reg[15:8]});

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        vaddr_next     = vaddr_reg;
        step_next      = step_reg;
        prefetch_next  = prefetch_reg;
        oaddr_next     = oaddr_reg;
        ophase_next    = ophase_reg;
        paddr_next     = paddr_reg;
        pphase_next    = pphase_reg;
        mat_a_next     = mat_a_reg;
        mat_b_next     = mat_b_reg;
        prev_next      = prev_reg;
        olow_next      = olow_reg;
        plow_next      = plow_reg;
        read_data_next = read_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        vmem_we    = 1'b0;
        vmem_waddr = vidx_reg;
        vmem_wdata = vmem_rdata;
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_waddr = oaddr_reg[9:1];
        odd_waddr  = oaddr_reg[9:1];
        even_wdata = wdata_reg;
        odd_wdata  = wdata_reg;
        pmem_we    = 1'b0;
        pmem_waddr = pidx_reg;
        pmem_wdata = {wdata_reg[6:0], plow_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                vmem_we    = 1'b1;
                vmem_waddr = clr_reg;
                vmem_wdata = 16'd0;
                even_we    = (clr_reg < VA_W'(OBJ_ROWS));
                odd_we     = even_we;
                even_waddr = clr_reg[OBJ_ROW_W-1:0];
                odd_waddr  = clr_reg[OBJ_ROW_W-1:0];
                even_wdata = 8'd0;
                odd_wdata  = 8'd0;
                pmem_we    = (clr_reg < VA_W'(PALETTE_DEPTH));
                pmem_waddr = clr_reg[PI_W-1:0];
                pmem_wdata = 15'd0;
                clr_next   = clr_reg + VA_W'(1);
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    read_data_next = 8'd0;
                    if (op_reg == OP_READ)
                    begin
                        case (roff_reg)
                            OFS_MPY_LO:  read_data_next = product[7:0];
                            OFS_MPY_MID: read_data_next = product[15:8];
                            OFS_MPY_HI:  read_data_next = product[23:16];
                            OFS_OAM_READ:
                            begin
                                read_data_next = oidx_reg[0] ? odd_rdata : even_rdata;
                                oaddr_next     = oinc_wrap[9:0];
                            end
                            OFS_VRAM_READ_LO, OFS_VRAM_READ_HI:
                            begin
                                read_data_next = (roff_reg == OFS_VRAM_READ_HI)
                                                 ? prefetch_reg[15:8] : prefetch_reg[7:0];
                                prefetch_next  = vmem_rdata;
                                if (step_reg[7] == (roff_reg == OFS_VRAM_READ_HI))
                                begin
                                    vaddr_next = vstep;
                                end
                            end
                            OFS_CG_READ:
                            begin
                                read_data_next = pphase_reg ? {1'b0, pmem_rdata[14:8]}
                                                            : pmem_rdata[7:0];
                                pphase_next    = !pphase_reg;
                                if (pphase_reg)
                                begin
                                    paddr_next = paddr_reg + 8'd1;
                                end
                            end
                            OFS_VERSION_A, OFS_VERSION_B: read_data_next = VERSION_BYTE;
                            default:                      read_data_next = 8'd0;
                        endcase
                    end
                    else
                    begin
                        case (roff_reg)
                            OFS_OAM_ADDR_LO:
                            begin
                                oaddr_next  = {oaddr_reg[9], wdata_reg, 1'b0};
                                ophase_next = 1'b0;
                            end
                            OFS_OAM_ADDR_HI:
                            begin
                                oaddr_next  = {wdata_reg[0], oaddr_reg[8:1], 1'b0};
                                ophase_next = 1'b0;
                            end
                            OFS_OAM_DATA:
                            begin
                                if (oaddr_reg < OBJ_HIGH_BASE)
                                begin
                                    if (!ophase_reg)
                                    begin
                                        olow_next   = wdata_reg;
                                        ophase_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // The pair straddles the banks; an odd start puts the
                                        // second byte in the next even row.
                                        even_we     = 1'b1;
                                        odd_we      = 1'b1;
                                        even_waddr  = oaddr_reg[0] ? ohi[9:1] : oaddr_reg[9:1];
                                        even_wdata  = oaddr_reg[0] ? wdata_reg : olow_reg;
                                        odd_wdata   = oaddr_reg[0] ? olow_reg : wdata_reg;
                                        oaddr_next  = oaddr_reg + 10'd2;
                                        ophase_next = 1'b0;
                                    end
                                end
                                else if ({1'b0, oaddr_reg} < OBJ_DEPTH)
                                begin
                                    even_we    = !oaddr_reg[0];
                                    odd_we     = oaddr_reg[0];
                                    oaddr_next = oaddr_reg + 10'd1;
                                end
                            end
                            OFS_SCROLL_A, OFS_SCROLL_B, OFS_MATRIX_C, OFS_MATRIX_D:
                            begin
                                prev_next = wdata_reg;
                            end
                            OFS_VRAM_MODE:    step_next = wdata_reg;
                            OFS_VRAM_ADDR_LO: vaddr_next = {vaddr_reg[15:8], wdata_reg};
                            OFS_VRAM_ADDR_HI: vaddr_next = {wdata_reg, vaddr_reg[7:0]};
                            OFS_VRAM_DATA_LO:
                            begin
                                vmem_we    = 1'b1;
                                vmem_wdata = {vmem_rdata[15:8], wdata_reg};
                                if (!step_reg[7])
                                begin
                                    vaddr_next = vstep;
                                end
                            end
                            OFS_VRAM_DATA_HI:
                            begin
                                vmem_we    = 1'b1;
                                vmem_wdata = {wdata_reg, vmem_rdata[7:0]};
                                if (step_reg[7])
                                begin
                                    vaddr_next = vstep;
                                end
                            end
                            OFS_MATRIX_A:
                            begin
                                mat_a_next = {wdata_reg, prev_reg};
                                prev_next  = wdata_reg;
                            end
                            OFS_MATRIX_B:
                            begin
                                mat_b_next = {wdata_reg, prev_reg};
                                prev_next  = wdata_reg;
                            end
                            OFS_CG_ADDR:
                            begin
                                paddr_next  = wdata_reg;
                                pphase_next = 1'b0;
                            end
                            OFS_CG_DATA:
                            begin
                                if (!pphase_reg)
                                begin
                                    plow_next   = wdata_reg;
                                    pphase_next = 1'b1;
                                end
                                else
                                begin
                                    pmem_we     = 1'b1;
                                    paddr_next  = paddr_reg + 8'd1;
                                    pphase_next = 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            vaddr_reg     <= 16'd0;
            step_reg      <= 8'd0;
            prefetch_reg  <= 16'd0;
            oaddr_reg     <= 10'd0;
            ophase_reg    <= 1'b0;
            paddr_reg     <= 8'd0;
            pphase_reg    <= 1'b0;
            mat_a_reg     <= MATRIX_A_RESET;
            mat_b_reg     <= 16'd0;
            prev_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
            read_data_reg <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            vaddr_reg     <= vaddr_next;
            step_reg      <= step_next;
            prefetch_reg  <= prefetch_next;
            oaddr_reg     <= oaddr_next;
            ophase_reg    <= ophase_next;
            paddr_reg     <= paddr_next;
            pphase_reg    <= pphase_next;
            mat_a_reg     <= mat_a_next;
            mat_b_reg     <= mat_b_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            read_data_reg <= read_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vq_reg        <= vprod[38:32];
        pq_reg        <= pprod[20:16];
        olow_reg      <= olow_next;
        plow_reg      <= plow_next;
        if (in_accept)
        begin
            op_reg    <= op;
            roff_reg  <= reg_offset;
            wdata_reg <= write_data;
        end
        if (mem_re)
        begin
            vidx_reg <= vidx;
            pidx_reg <= pidx;
            oidx_reg <= oidx;
        end
    end

    // Video word memory.
    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= vmem_wdata;
        end
        if (mem_re)
        begin
            vmem_rdata <= vmem[vidx];
        end
    end

    // Object byte banks: even and odd addresses.
    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            obj_even[even_waddr] <= even_wdata;
        end
        if (mem_re)
        begin
            even_rdata <= obj_even[oidx[9:1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (odd_we)
        begin
            obj_odd[odd_waddr] <= odd_wdata;
        end
        if (mem_re)
        begin
            odd_rdata <= obj_odd[oidx[9:1]];
        end
    end

    // Palette word memory.
    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            pmem[pmem_waddr] <= pmem_wdata;
        end
        if (mem_re)
        begin
            pmem_rdata <= pmem[pidx];
        end
    end

endmodule
